/* hdl/frame_run_segment_grouper_assert.svh */
// Assertion macros for the frame run segment grouper.
// Expects clk and arst_n in the scope of the module that uses them.
`ifndef FRAME_RUN_SEGMENT_GROUPER_ASSERT_SVH
`define FRAME_RUN_SEGMENT_GROUPER_ASSERT_SVH

// same-cycle implication
`define FRSG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FRSG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/frsg_pkg.sv */
// Shared constants and types of the frame run segment grouper.
// No dependencies.
package frsg_pkg;

	localparam int CHANNELS       = 8;
	localparam int SEGS_PER_GROUP = 8;
	localparam int INDEX_BITS     = 24;
	localparam int END_BITS       = INDEX_BITS + 1;
	localparam int DIFF_BITS      = END_BITS + 2;
	localparam int CFG_BITS       = 16;
	localparam int CH_IDX_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SEG_W          = (SEGS_PER_GROUP > 1) ? $clog2(SEGS_PER_GROUP) : 1;
	localparam int CNT_W          = $clog2(SEGS_PER_GROUP + 1);
	localparam int MEM_DEPTH      = CHANNELS * SEGS_PER_GROUP;
	localparam int MEM_AW         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int PADDR_W        = 3;

	localparam logic [CFG_BITS-1:0] GAP_LIMIT_RESET = CFG_BITS'(30);
	localparam logic [CFG_BITS-1:0] MIN_SPAN_RESET  = CFG_BITS'(30);

	localparam logic REG_GAP_LIMIT = 1'b0;
	localparam logic REG_MIN_SPAN  = 1'b1;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	typedef struct packed {
		logic                  command;
		logic [2:0]            channel;
		logic [23:0]           frame_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]            out_channel;
		logic [23:0]           seg_start;
		logic [24:0]           seg_end;
		logic                  group_last;
	} out_item_t;

	typedef struct packed {
		logic [CFG_BITS-1:0]   gap_limit;
		logic [CFG_BITS-1:0]   min_span;
	} cfg_t;

	typedef struct packed {
		logic [END_BITS-1:0]   a;
		logic [END_BITS-1:0]   b;
		logic [CFG_BITS-1:0]   limit;
	} cmp_req_t;

	typedef struct packed {
		logic                  below;
	} cmp_rsp_t;

endpackage

/* hdl/frsg_cfg_regs.sv */
// Configuration registers (gap limit, minimum span) behind an APB-style port.
// Depends on frsg_pkg.
module frsg_cfg_regs
	import frsg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_limit <= GAP_LIMIT_RESET;
			cfg_q.min_span  <= MIN_SPAN_RESET;
		end else if (wr_en) begin
			case (paddr[2])
				REG_GAP_LIMIT: cfg_q.gap_limit <= pwdata[CFG_BITS-1:0];
				REG_MIN_SPAN:  cfg_q.min_span  <= pwdata[CFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_GAP_LIMIT: prdata = {16'b0, cfg_q.gap_limit};
			REG_MIN_SPAN:  prdata = {16'b0, cfg_q.min_span};
			default:       prdata = 32'b0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

/* hdl/frsg_cmp_unit.sv */
// Shared signed subtract-and-compare unit: tells whether a - b < limit.
// Depends on frsg_pkg.
module frsg_cmp_unit
	import frsg_pkg::*;
(
	input  cmp_req_t req,
	output cmp_rsp_t rsp
);

	logic signed [DIFF_BITS-1:0] diff;
	logic signed [DIFF_BITS-1:0] lim;

	assign diff      = $signed({2'b00, req.a}) - $signed({2'b00, req.b});
	assign lim       = $signed({{(DIFF_BITS-CFG_BITS){1'b0}}, req.limit});
	assign rsp.below = (diff < lim);

endmodule

/* hdl/frame_run_segment_grouper.sv */
// Top level of the frame run segment grouper: sequencer, per-channel run and
// group state, segment memory and output register. Depends on frsg_pkg,
// frsg_cfg_regs, frsg_cmp_unit and frame_run_segment_grouper_assert.svh.
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall   | in_item_t  (command, channel, frame_index)
//  out     | output    | out_valid / out_stall | out_item_t (channel, start, end, last)
//  cfg     | input     | APB psel / penable    | gap_limit, min_span
//
// A frame that starts or extends its run passes through the run state only; one that
// closes a segment goes on through add and write, or, when its group closes, through
// add, close, a read and an emit per emitted segment, and write. A flush also reaches
// close, after add and write when a run is active. The single compare unit serves both
// the gap and the span check. in_stall stays high while a transaction is in work.
// Reset clears run and group state at once; no clearing pass.
// A stalled output holds its transaction and the sequencer waits in emit.
module frame_run_segment_grouper
	import frsg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_item_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	`include "frame_run_segment_grouper_assert.svh"

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RUN   = 7'b0000010,
		S_ADD   = 7'b0000100,
		S_CLOSE = 7'b0001000,
		S_READ  = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_WRITE = 7'b1000000
	} state_t;

	cfg_t     cfg;
	cmp_req_t cmp_req;
	cmp_rsp_t cmp_rsp;

	frsg_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	frsg_cmp_unit u_cmp (
		.req (cmp_req),
		.rsp (cmp_rsp)
	);

	state_t                state_q;
	logic                  cmd_q;
	logic [2:0]            ch_q;
	logic [INDEX_BITS-1:0] idx_q;
	logic [INDEX_BITS-1:0] seg_s_q;
	logic [END_BITS-1:0]   seg_e_q;
	logic                  add_pend_q;
	logic                  close_after_q;
	logic [CNT_W-1:0]      k_q;

	logic                  run_active_q [CHANNELS];
	logic [INDEX_BITS-1:0] run_start_q  [CHANNELS];
	logic [INDEX_BITS-1:0] run_last_q   [CHANNELS];
	logic [CNT_W-1:0]      grp_cnt_q    [CHANNELS];
	logic [INDEX_BITS-1:0] grp_first_q  [CHANNELS];
	logic [END_BITS-1:0]   grp_end_q    [CHANNELS];

	logic [END_BITS+INDEX_BITS-1:0] seg_mem [MEM_DEPTH];
	logic [END_BITS+INDEX_BITS-1:0] rdata_q;

	logic                  out_valid_q;
	out_item_t             out_data_q;

	logic [CH_IDX_W-1:0]   ch_idx;
	logic                  ch_ok;
	logic [END_BITS-1:0]   next_idx;
	logic                  in_fire;
	logic                  out_free;
	logic                  emit_fire;
	logic                  emit_last;
	logic [CNT_W-1:0]      cnt_cur;
	logic [MEM_AW-1:0]     rd_addr;
	logic [MEM_AW-1:0]     wr_addr;
	logic                  wr_en;

	assign ch_idx    = ch_q[CH_IDX_W-1:0];
	assign ch_ok     = (32'(ch_q) < CHANNELS);
	assign next_idx  = {1'b0, run_last_q[ch_idx]} + END_BITS'(1);
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid & ~in_stall;
	assign out_free  = ~out_valid_q | ~out_stall;
	assign emit_fire = (state_q == S_EMIT) & out_free;
	assign cnt_cur   = grp_cnt_q[ch_idx];
	assign emit_last = ((k_q + CNT_W'(1)) == cnt_cur);
	assign rd_addr   = MEM_AW'(32'(ch_idx) * SEGS_PER_GROUP + 32'(k_q[SEG_W-1:0]));
	assign wr_addr   = MEM_AW'(32'(ch_idx) * SEGS_PER_GROUP + 32'(cnt_cur[SEG_W-1:0]));
	assign wr_en     = (state_q == S_WRITE);

	always_comb begin
		cmp_req.a     = {1'b0, seg_s_q};
		cmp_req.b     = grp_end_q[ch_idx];
		cmp_req.limit = cfg.gap_limit;
		if (state_q == S_CLOSE) begin
			cmp_req.a     = grp_end_q[ch_idx];
			cmp_req.b     = {1'b0, grp_first_q[ch_idx]};
			cmp_req.limit = cfg.min_span;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			seg_mem[wr_addr] <= {seg_e_q, seg_s_q};
		end
		rdata_q <= seg_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q <= in_data.command;
			ch_q  <= in_data.channel;
			idx_q <= in_data.frame_index;
		end
		if (wr_en) begin
			if (cnt_cur == '0) begin
				grp_first_q[ch_idx] <= seg_s_q;
			end
			grp_end_q[ch_idx] <= seg_e_q;
		end
		if (state_q == S_RUN) begin
			seg_s_q <= run_start_q[ch_idx];
			seg_e_q <= next_idx;
		end
		if (emit_fire) begin
			out_data_q.out_channel <= ch_q;
			out_data_q.seg_start   <= rdata_q[INDEX_BITS-1:0];
			out_data_q.seg_end     <= rdata_q[END_BITS+INDEX_BITS-1:INDEX_BITS];
			out_data_q.group_last  <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			add_pend_q    <= 1'b0;
			close_after_q <= 1'b0;
			k_q           <= '0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				run_active_q[i] <= 1'b0;
				run_start_q[i]  <= '0;
				run_last_q[i]   <= '0;
				grp_cnt_q[i]    <= '0;
			end
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (~out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (!ch_ok) begin
						state_q <= S_IDLE;
					end else if (cmd_q == CMD_FRAME) begin
						run_last_q[ch_idx] <= idx_q;
						if (!run_active_q[ch_idx]) begin
							run_active_q[ch_idx] <= 1'b1;
							run_start_q[ch_idx]  <= idx_q;
							state_q              <= S_IDLE;
						end else if ({1'b0, idx_q} == next_idx) begin
							state_q <= S_IDLE;
						end else begin
							run_start_q[ch_idx] <= idx_q;
							add_pend_q          <= 1'b1;
							state_q             <= S_ADD;
						end
					end else begin
						run_active_q[ch_idx] <= 1'b0;
						if (run_active_q[ch_idx]) begin
							add_pend_q    <= 1'b1;
							close_after_q <= 1'b1;
							state_q       <= S_ADD;
						end else begin
							state_q <= S_CLOSE;
						end
					end
				end
				S_ADD: begin
					if (cnt_cur == '0) begin
						state_q <= S_WRITE;
					end else if (cmp_rsp.below && (32'(cnt_cur) < SEGS_PER_GROUP)) begin
						state_q <= S_WRITE;
					end else begin
						state_q <= S_CLOSE;
					end
				end
				S_CLOSE: begin
					k_q <= '0;
					if ((cnt_cur != '0) && !cmp_rsp.below) begin
						state_q <= S_READ;
					end else begin
						grp_cnt_q[ch_idx] <= '0;
						state_q           <= add_pend_q ? S_WRITE : S_IDLE;
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						k_q <= k_q + CNT_W'(1);
						if (emit_last) begin
							grp_cnt_q[ch_idx] <= '0;
							state_q           <= add_pend_q ? S_WRITE : S_IDLE;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_WRITE: begin
					grp_cnt_q[ch_idx] <= cnt_cur + CNT_W'(1);
					add_pend_q        <= 1'b0;
					if (close_after_q) begin
						close_after_q <= 1'b0;
						state_q       <= S_CLOSE;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`FRSG_ASSERT_NEXT(a_accept_runs, in_fire, state_q == S_RUN, "accepted item did not start")
	`FRSG_ASSERT_NOW(a_rise_from_emit, $rose(out_valid_q), $past(state_q) == S_EMIT,
		"output raised outside emit")
	`FRSG_ASSERT_NOW(a_cnt_bound, state_q != S_IDLE, 32'(cnt_cur) <= SEGS_PER_GROUP,
		"group count beyond buffer size")
	`FRSG_ASSERT_NEXT(a_last_clears, emit_fire && emit_last, grp_cnt_q[ch_idx] == '0,
		"group not cleared after last segment")
	`FRSG_ASSERT_NOW(a_write_has_room, wr_en, 32'(cnt_cur) < SEGS_PER_GROUP,
		"segment written into full group")

endmodule

/* bench/frame_run_segment_grouper_test.sv */
// Self-checking bench for frame_run_segment_grouper: directed and random frame
// and flush transactions, checked against an in-bench model of runs and groups.
// Depends on frsg_pkg and the frame_run_segment_grouper RTL.
`timescale 1ns / 100ps

module frame_run_segment_grouper_test;
	import frsg_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	frame_run_segment_grouper u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	initial forever #1 clk = ~clk;

	in_item_t  pending_events[$];
	out_item_t seg_expect[$];
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fails = 0;
	int quiet_cycles = 0;
	bit in_taken = 1'b0;

	// shadow of the block's state and registers
	logic [CFG_BITS-1:0]   gap_limit_sh;
	logic [CFG_BITS-1:0]   min_span_sh;
	bit                    run_on [CHANNELS];
	logic [INDEX_BITS-1:0] run_first [CHANNELS];
	logic [INDEX_BITS-1:0] run_prev [CHANNELS];
	logic [INDEX_BITS-1:0] grp_lo [CHANNELS][SEGS_PER_GROUP];
	logic [END_BITS-1:0]   grp_hi [CHANNELS][SEGS_PER_GROUP];
	int                    grp_cnt [CHANNELS];

	logic [INDEX_BITS-1:0] stim_last [CHANNELS];

	task automatic close_group(input int ch);
		longint span, hi_v, lo_v;
		int cnt;
		out_item_t seg;
		cnt = grp_cnt[ch];
		if (cnt != 0) begin
			hi_v = grp_hi[ch][cnt-1];
			lo_v = grp_lo[ch][0];
			span = hi_v - lo_v;
			if (span >= longint'(min_span_sh)) begin
				for (int k = 0; k < cnt; k++) begin
					seg.out_channel = 3'(ch);
					seg.seg_start = grp_lo[ch][k];
					seg.seg_end = grp_hi[ch][k];
					seg.group_last = (k + 1 == cnt);
					seg_expect = {seg_expect, seg};
				end
			end
		end
		grp_cnt[ch] = 0;
	endtask

	task automatic add_segment(input int ch, input logic [INDEX_BITS-1:0] s,
			input logic [END_BITS-1:0] e);
		longint gap, s_v, hi_v;
		int cnt;
		cnt = grp_cnt[ch];
		if (cnt != 0) begin
			s_v = s;
			hi_v = grp_hi[ch][cnt-1];
			gap = s_v - hi_v;
			if (!(gap < longint'(gap_limit_sh)) || cnt >= SEGS_PER_GROUP) begin
				close_group(ch);
				cnt = 0;
			end
		end
		grp_lo[ch][cnt] = s;
		grp_hi[ch][cnt] = e;
		grp_cnt[ch] = cnt + 1;
	endtask

	task automatic track_event(input in_item_t ev);
		int ch;
		logic [END_BITS-1:0] next_idx;
		ch = ev.channel;
		next_idx = {1'b0, run_prev[ch]} + 1'b1;
		if (ev.command == CMD_FRAME) begin
			if (run_on[ch]) begin
				if ({1'b0, ev.frame_index} != next_idx) begin
					add_segment(ch, run_first[ch], next_idx);
					run_first[ch] = ev.frame_index;
				end
			end else begin
				run_on[ch] = 1'b1;
				run_first[ch] = ev.frame_index;
			end
			run_prev[ch] = ev.frame_index;
		end else begin
			if (run_on[ch])
				add_segment(ch, run_first[ch], next_idx);
			close_group(ch);
			run_on[ch] = 1'b0;
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_events.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				in_data <= pending_events.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		out_item_t want;
		bit out_taken;
		in_taken = in_valid && !in_stall;
		out_taken = out_valid && !out_stall;
		if (arst_n) begin
			if (in_taken)
				track_event(in_data);
			if (out_taken) begin
				if (seg_expect.size() == 0) begin
					fails++;
					$display("%0t unexpected segment: expected none, got ch %0d [%0h, %0h) last %0b",
						$time, out_data.out_channel, out_data.seg_start,
						out_data.seg_end, out_data.group_last);
				end else begin
					want = seg_expect.pop_front();
					if (out_data.out_channel !== want.out_channel
							|| out_data.seg_start !== want.seg_start
							|| out_data.seg_end !== want.seg_end
							|| out_data.group_last !== want.group_last) begin
						fails++;
						$display("%0t segment mismatch: expected ch %0d [%0h, %0h) last %0b, got ch %0d [%0h, %0h) last %0b",
							$time, want.out_channel, want.seg_start, want.seg_end,
							want.group_last, out_data.out_channel, out_data.seg_start,
							out_data.seg_end, out_data.group_last);
					end
				end
			end
			if (in_taken || out_taken)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= 4000) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, quiet_cycles);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic queue_event(input logic cmd, input logic [2:0] ch,
			input logic [INDEX_BITS-1:0] idx);
		in_item_t ev;
		ev.command = cmd;
		ev.channel = ch;
		ev.frame_index = idx;
		pending_events = {pending_events, ev};
	endtask

	function automatic in_item_t random_event();
		in_item_t ev;
		logic [2:0] ch;
		int pick;
		ch = ($urandom_range(0, 99) < 65) ? 3'($urandom_range(0, 2))
			: 3'($urandom_range(0, CHANNELS - 1));
		ev.channel = ch;
		ev.command = CMD_FRAME;
		ev.frame_index = INDEX_BITS'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 10)
			ev.command = CMD_FLUSH;
		else if (pick < 55)
			ev.frame_index = stim_last[ch] + 1'b1;
		else if (pick < 78)
			ev.frame_index = stim_last[ch] + INDEX_BITS'($urandom_range(2, 40));
		else if (pick < 86)
			ev.frame_index = stim_last[ch] - INDEX_BITS'($urandom_range(0, 20));
		else if (pick >= 94)
			ev.frame_index = {INDEX_BITS{1'b1}} - INDEX_BITS'($urandom_range(0, 2));
		if (ev.command == CMD_FRAME)
			stim_last[ch] = ev.frame_index;
		return ev;
	endfunction

	task automatic wait_drained();
		while (pending_events.size() != 0 || in_valid || seg_expect.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic run_batch(input int count);
		in_item_t ev;
		@(posedge clk);
		repeat (count) begin
			ev = random_event();
			pending_events = {pending_events, ev};
		end
		wait_drained();
	endtask

	task automatic cfg_write(input logic reg_sel, input logic [CFG_BITS-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == REG_GAP_LIMIT)
			gap_limit_sh = value;
		else
			min_span_sh = value;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		gap_limit_sh = GAP_LIMIT_RESET;
		min_span_sh = MIN_SPAN_RESET;
		for (int c = 0; c < CHANNELS; c++) begin
			run_on[c] = 1'b0;
			run_first[c] = '0;
			run_prev[c] = '0;
			grp_cnt[c] = 0;
			stim_last[c] = '0;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// kept group of three segments, ended by flush
		queue_event(CMD_FRAME, 3'd0, 24'd0);
		queue_event(CMD_FRAME, 3'd0, 24'd20);
		queue_event(CMD_FRAME, 3'd0, 24'd45);
		queue_event(CMD_FLUSH, 3'd0, 24'hFFFFFF);
		// runs at the top of the index range
		queue_event(CMD_FRAME, 3'd1, 24'hFFFFE0);
		queue_event(CMD_FRAME, 3'd1, 24'hFFFFF0);
		queue_event(CMD_FRAME, 3'd1, 24'hFFFFFF);
		queue_event(CMD_FLUSH, 3'd1, 24'd0);
		queue_event(CMD_FRAME, 3'd1, 24'hFFFFFF);
		queue_event(CMD_FRAME, 3'd1, 24'd0);
		queue_event(CMD_FLUSH, 3'd1, 24'd0);
		// negative gap joins, negative span drops the group
		queue_event(CMD_FRAME, 3'd2, 24'd100);
		queue_event(CMD_FRAME, 3'd2, 24'd50);
		queue_event(CMD_FLUSH, 3'd2, 24'd0);
		// full group closes early
		for (int k = 0; k <= 9; k++)
			queue_event(CMD_FRAME, 3'd3, 24'(5 * k));
		queue_event(CMD_FLUSH, 3'd3, 24'd0);
		// flush with no active run
		queue_event(CMD_FLUSH, 3'd7, 24'h123456);
		wait_drained();

		cfg_write(REG_GAP_LIMIT, 16'hFFFF);
		cfg_write(REG_MIN_SPAN, 16'h0000);
		run_batch(24);

		cfg_write(REG_GAP_LIMIT, 16'h0000);
		send_idle_pct = 79;
		run_batch(24);

		cfg_write(REG_GAP_LIMIT, 16'hFFFF);
		cfg_write(REG_MIN_SPAN, 16'hFFFF);
		send_idle_pct = 0;
		recv_stall_pct = 79;
		run_batch(24);

		cfg_write(REG_GAP_LIMIT, 16'($urandom_range(0, 64)));
		cfg_write(REG_MIN_SPAN, 16'($urandom_range(0, 64)));
		send_idle_pct = 25;
		recv_stall_pct = 25;
		run_batch(24);

		if (fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
+incdir+hdl
hdl/frsg_pkg.sv
hdl/frsg_cfg_regs.sv
hdl/frsg_cmp_unit.sv
hdl/frame_run_segment_grouper.sv
bench/frame_run_segment_grouper_test.sv
